>>> rtl/first_match_prefix_router_defines.svh
// Assertion macros for the first-match prefix router.
// Used by the top level only; they compile away when SYNTHESIS is defined.
`ifndef FIRST_MATCH_PREFIX_ROUTER_DEFINES_SVH
`define FIRST_MATCH_PREFIX_ROUTER_DEFINES_SVH

`ifndef SYNTHESIS
`define FMPR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmpr assertion failed");
`define FMPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmpr assertion failed");
`else
`define FMPR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FMPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/fmpr_pkg.sv
// Shared types, constants and helpers of the first-match prefix router.
// No dependencies; used by fmpr_cell and first_match_prefix_router.
`timescale 1ns / 1ps

package fmpr_pkg;

    localparam int FMPR_TABLE_DEPTH = 16;
    localparam int FMPR_NUM_CNT     = 5;

    localparam logic [31:0] FMPR_BLOCKED_RESET = 32'hA882_C001;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_BLOCKED = 2'd1;

    // outcome counter slots
    localparam logic [2:0] CNT_DIRECT   = 3'd0;
    localparam logic [2:0] CNT_HOP_B    = 3'd1;
    localparam logic [2:0] CNT_HOP_C    = 3'd2;
    localparam logic [2:0] CNT_UNROUTED = 3'd3;
    localparam logic [2:0] CNT_EXPIRED  = 3'd4;

    // entry hop codes
    localparam logic [1:0] HOP_B = 2'd1;
    localparam logic [1:0] HOP_C = 2'd2;

    typedef enum logic [2:0] {
        V_DIRECT  = 3'd0,
        V_HOP_B   = 3'd1,
        V_HOP_C   = 3'd2,
        V_NOMATCH = 3'd3,
        V_EXPIRED = 3'd4,
        V_BLOCKED = 3'd5
    } t_verdict;

    // search token passed from cell to cell
    typedef struct packed {
        logic        vld;
        logic [31:0] dest;
        logic        hit;
        logic [1:0]  hop;
    } t_token;

    // route entry write broadcast to every cell
    typedef struct packed {
        logic        we;
        logic [3:0]  slot;
        logic [31:0] network;
        logic [5:0]  prefix;
        logic [1:0]  hop;
    } t_load;

    // leading-ones mask; zero length gives no bits, 32 and above give all
    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        logic [31:0] m;
        if (plen >= 6'd32) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = ~(32'hFFFF_FFFF >> plen);
        end
        return m;
    endfunction

    function automatic t_verdict hop_verdict(input logic [1:0] hop);
        t_verdict v;
        if (hop == HOP_B) begin
            v = V_HOP_B;
        end else if (hop == HOP_C) begin
            v = V_HOP_C;
        end else begin
            v = V_DIRECT;
        end
        return v;
    endfunction

    function automatic logic [2:0] verdict_counter(input t_verdict v);
        logic [2:0] c;
        unique case (v)
            V_DIRECT:  c = CNT_DIRECT;
            V_HOP_B:   c = CNT_HOP_B;
            V_HOP_C:   c = CNT_HOP_C;
            V_EXPIRED: c = CNT_EXPIRED;
            default:   c = CNT_UNROUTED;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/fmpr_cell.sv
// One route table cell: holds a single entry and one stage of the search token.
// Depends on fmpr_pkg (t_token, t_load, prefix_mask).
`timescale 1ns / 1ps

module fmpr_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_active,
    input  fmpr_pkg::t_load i_load,
    input  fmpr_pkg::t_token i_tok,
    output fmpr_pkg::t_token o_tok
);

    logic [31:0] r_net;
    logic [31:0] r_mask;
    logic [1:0]  r_hop;

    fmpr_pkg::t_token r_tok;
    fmpr_pkg::t_token n_tok;

    logic w_match;

    // entry storage, written by a load transaction addressed to this slot
    always_ff @(posedge i_clk) begin
        if (i_load.we && (32'(i_load.slot) == IDX)) begin
            r_net  <= i_load.network;
            r_mask <= fmpr_pkg::prefix_mask(i_load.prefix);
            r_hop  <= i_load.hop;
        end
    end

    assign w_match = i_active && ((i_tok.dest & r_mask) == r_net);

    always_comb begin
        n_tok = r_tok;
        if (i_adv) begin
            n_tok = i_tok;
            // first match wins: an earlier hit passes through untouched
            if (i_tok.vld && !i_tok.hit && w_match) begin
                n_tok.hit = 1'b1;
                n_tok.hop = r_hop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> rtl/first_match_prefix_router.sv
// first_match_prefix_router: first-match IPv4 route lookup with outcome counters.
// Input channel (i_valid/o_ready) carries load transactions (i_mode 0), which
// write one route entry and give no result, and packet transactions (i_mode 1).
// Output channel (o_valid/i_ready) returns one result per packet: verdict,
// decremented TTL (zero if blocked) and the five saturating counters after it.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data, with no wait.
// A packet runs down a chain of TABLE_DEPTH cells, one cell per cycle while the
// chain is not held, and o_valid rises once it leaves the last cell; a new
// packet is not accepted until the last one has left the chain. Loads are
// accepted back to back while no packet is in the chain.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver stalls and a second packet reaches the chain
// end, the chain holds until the output register frees up.
// Reset clears the counters, entries_in_use and the handshake state, and
// sets the blocked address to 168.130.192.1. Route entries are undefined
// until loaded.
// Depends on fmpr_pkg, fmpr_cell and first_match_prefix_router_defines.svh.
`timescale 1ns / 1ps
`include "first_match_prefix_router_defines.svh"

module first_match_prefix_router #(
    parameter int TABLE_DEPTH = fmpr_pkg::FMPR_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [3:0]  i_entry_slot,
    input  logic [31:0] i_entry_network,
    input  logic [5:0]  i_entry_prefix_len,
    input  logic [1:0]  i_entry_hop,
    input  logic [31:0] i_dest_addr,
    input  logic [15:0] i_ttl_in,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_ttl_out,
    output logic [31:0] o_direct_count,
    output logic [31:0] o_hop_b_count,
    output logic [31:0] o_hop_c_count,
    output logic [31:0] o_unrouted_count,
    output logic [31:0] o_expired_count
);

    // configuration registers
    logic [4:0]  r_entries;
    logic [31:0] r_blocked;

    // handshake and per-packet state
    logic                r_busy;
    logic                r_pre_hit;
    fmpr_pkg::t_verdict  r_pre_verdict;
    logic [15:0]         r_pkt_ttl;

    logic                r_out_vld;
    fmpr_pkg::t_verdict  r_verdict;
    logic [15:0]         r_ttl_out;

    logic [31:0] r_cnt [fmpr_pkg::FMPR_NUM_CNT];
    logic [31:0] n_cnt [fmpr_pkg::FMPR_NUM_CNT];

    logic                w_acc;
    logic                w_pkt_acc;
    logic                w_blocked;
    logic [15:0]         w_ttl_dec;
    logic                w_adv;
    logic                w_fin;
    fmpr_pkg::t_verdict  w_final;
    logic [2:0]          w_cidx;
    fmpr_pkg::t_load     w_load;
    logic [TABLE_DEPTH-1:0] w_active;
    logic [TABLE_DEPTH-1:0] w_vlds;
    fmpr_pkg::t_token    w_tok [TABLE_DEPTH+1];

    assign o_ready   = !r_busy;
    assign w_acc     = i_valid && o_ready;
    assign w_pkt_acc = w_acc && i_mode;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
            r_blocked <= fmpr_pkg::FMPR_BLOCKED_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fmpr_pkg::CFG_ENTRIES) begin
                r_entries <= i_cfg_data[4:0];
            end else if (i_cfg_idx == fmpr_pkg::CFG_BLOCKED) begin
                r_blocked <= i_cfg_data;
            end
        end
    end

    // ---------------- head of the chain ----------------
    assign w_blocked = (i_dest_addr == r_blocked);
    assign w_ttl_dec = i_ttl_in - 16'd1;

    always_ff @(posedge i_clk) begin
        if (w_pkt_acc) begin
            r_pre_hit     <= w_blocked || (w_ttl_dec == 16'd0);
            r_pre_verdict <= w_blocked ? fmpr_pkg::V_BLOCKED : fmpr_pkg::V_EXPIRED;
            r_pkt_ttl     <= w_blocked ? 16'd0 : w_ttl_dec;
        end
    end

    assign w_load.we      = w_acc && !i_mode;
    assign w_load.slot    = i_entry_slot;
    assign w_load.network = i_entry_network;
    assign w_load.prefix  = i_entry_prefix_len;
    assign w_load.hop     = i_entry_hop;

    assign w_tok[0].vld  = w_pkt_acc;
    assign w_tok[0].dest = i_dest_addr;
    assign w_tok[0].hit  = 1'b0;
    assign w_tok[0].hop  = 2'd0;

    // ---------------- cell chain ----------------
    // hold the whole chain while a finished token waits for the output register
    assign w_fin = w_tok[TABLE_DEPTH].vld && (!r_out_vld || i_ready);
    assign w_adv = !w_tok[TABLE_DEPTH].vld || w_fin;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_active[g] = (32'(r_entries) > g);
        assign w_vlds[g]   = w_tok[g+1].vld;

        fmpr_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_active (w_active[g]),
            .i_load   (w_load),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_pkt_acc) begin
            r_busy <= 1'b1;
        end else if (w_fin) begin
            r_busy <= 1'b0;
        end
    end

    // ---------------- verdict and counters ----------------
    always_comb begin
        if (r_pre_hit) begin
            w_final = r_pre_verdict;
        end else if (w_tok[TABLE_DEPTH].hit) begin
            w_final = fmpr_pkg::hop_verdict(w_tok[TABLE_DEPTH].hop);
        end else begin
            w_final = fmpr_pkg::V_NOMATCH;
        end
    end

    assign w_cidx = fmpr_pkg::verdict_counter(w_final);

    always_comb begin
        for (int k = 0; k < fmpr_pkg::FMPR_NUM_CNT; k++) begin
            n_cnt[k] = r_cnt[k];
            // saturate at all ones
            if (w_fin && (w_cidx == 3'(k)) && (r_cnt[k] != 32'hFFFF_FFFF)) begin
                n_cnt[k] = r_cnt[k] + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fmpr_pkg::FMPR_NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fin) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_verdict <= w_final;
            r_ttl_out <= r_pkt_ttl;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_verdict        = r_verdict;
    assign o_ttl_out        = r_ttl_out;
    assign o_direct_count   = r_cnt[fmpr_pkg::CNT_DIRECT];
    assign o_hop_b_count    = r_cnt[fmpr_pkg::CNT_HOP_B];
    assign o_hop_c_count    = r_cnt[fmpr_pkg::CNT_HOP_C];
    assign o_unrouted_count = r_cnt[fmpr_pkg::CNT_UNROUTED];
    assign o_expired_count  = r_cnt[fmpr_pkg::CNT_EXPIRED];

    // ---------------- assertions ----------------
    `FMPR_ASSERT_SAME(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_vlds))
    `FMPR_ASSERT_SAME(a_fin_busy, i_clk, i_rst_n, w_fin, r_busy && !w_pkt_acc)
    `FMPR_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n, r_out_vld && i_ready && !w_fin, !r_out_vld)

endmodule

>>> test/tb_first_match_prefix_router.sv
// Self-checking testbench for first_match_prefix_router: route loads and packet lookups
// with random handshake idling, checked against an in-bench lookup predictor.
// Depends on fmpr_pkg and the first_match_prefix_router RTL.
`timescale 1ns / 1ps

module tb_first_match_prefix_router;

    localparam logic       MODE_LOAD   = 1'b0;
    localparam logic       MODE_PACKET = 1'b1;
    localparam logic [1:0] HOP_DIRECT  = 2'd0;
    localparam logic [1:0] HOP_SPARE   = 2'd3;
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;
    localparam int         PHASES      = 5;
    localparam int         PHASE_ITEMS = 180;
    localparam int         STALL_LIMIT = 4000;

    typedef struct packed {
        logic        mode;
        logic [3:0]  slot;
        logic [31:0] network;
        logic [5:0]  plen;
        logic [1:0]  hop;
        logic [31:0] dest;
        logic [15:0] ttl;
    } t_route_item;

    typedef struct packed {
        fmpr_pkg::t_verdict verdict;
        logic [15:0]        ttl;
        logic [4:0][31:0]   cnt;
    } t_route_result;

    class route_scoreboard;
        logic [31:0]      net_tbl  [fmpr_pkg::FMPR_TABLE_DEPTH];
        logic [5:0]       plen_tbl [fmpr_pkg::FMPR_TABLE_DEPTH];
        logic [1:0]       hop_tbl  [fmpr_pkg::FMPR_TABLE_DEPTH];
        logic [4:0]       entries;
        logic [31:0]      blocked;
        logic [4:0][31:0] counts;
        t_route_result    pending_verdicts [$];
        int               mismatches;
        int               loads_seen;
        int               verdict_tally [6];

        function new();
            entries    = '0;
            blocked    = fmpr_pkg::FMPR_BLOCKED_RESET;
            counts     = '0;
            mismatches = 0;
            loads_seen = 0;
            foreach (net_tbl[i]) begin
                net_tbl[i]  = '0;
                plen_tbl[i] = '0;
                hop_tbl[i]  = '0;
            end
            foreach (verdict_tally[i]) verdict_tally[i] = 0;
        endfunction

        function logic [31:0] mask_of(input logic [5:0] plen);
            if (plen == 6'd0) return 32'h0;
            if (plen >= 6'd32) return 32'hFFFF_FFFF;
            return 32'hFFFF_FFFF << (6'd32 - plen);
        endfunction

        function void write_register(input logic [1:0] idx, input logic [31:0] data);
            unique case (idx)
                fmpr_pkg::CFG_ENTRIES: entries = data[4:0];
                fmpr_pkg::CFG_BLOCKED: blocked = data;
                default: ;
            endcase
        endfunction

        function void bump(input logic [2:0] which);
            if (counts[which] != 32'hFFFF_FFFF) counts[which] = counts[which] + 32'd1;
        endfunction

        function void route_accepted(input t_route_item it);
            t_route_result      r;
            logic [15:0]        dec;
            int                 span;
            int                 k;
            fmpr_pkg::t_verdict v;
            if (it.mode == MODE_LOAD) begin
                net_tbl[it.slot]  = it.network;
                plen_tbl[it.slot] = it.plen;
                hop_tbl[it.slot]  = it.hop;
                loads_seen++;
                return;
            end
            dec = it.ttl - 16'd1;
            if (it.dest == blocked) begin
                // TTL is never looked at for a blocked destination
                v   = fmpr_pkg::V_BLOCKED;
                dec = '0;
                bump(fmpr_pkg::CNT_UNROUTED);
            end else if (dec == 16'd0) begin
                v = fmpr_pkg::V_EXPIRED;
                bump(fmpr_pkg::CNT_EXPIRED);
            end else begin
                span = (entries > fmpr_pkg::FMPR_TABLE_DEPTH) ?
                       fmpr_pkg::FMPR_TABLE_DEPTH : int'(entries);
                v    = fmpr_pkg::V_NOMATCH;
                for (k = 0; k < span; k++) begin
                    if ((it.dest & mask_of(plen_tbl[k])) == net_tbl[k]) begin
                        if (hop_tbl[k] == fmpr_pkg::HOP_B) v = fmpr_pkg::V_HOP_B;
                        else if (hop_tbl[k] == fmpr_pkg::HOP_C) v = fmpr_pkg::V_HOP_C;
                        else v = fmpr_pkg::V_DIRECT;
                        break;
                    end
                end
                unique case (v)
                    fmpr_pkg::V_DIRECT: bump(fmpr_pkg::CNT_DIRECT);
                    fmpr_pkg::V_HOP_B:  bump(fmpr_pkg::CNT_HOP_B);
                    fmpr_pkg::V_HOP_C:  bump(fmpr_pkg::CNT_HOP_C);
                    default:            bump(fmpr_pkg::CNT_UNROUTED);
                endcase
            end
            verdict_tally[v]++;
            r.verdict = v;
            r.ttl     = dec;
            r.cnt     = counts;
            pending_verdicts.push_back(r);
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            mismatches++;
            if (mismatches <= 30)
                $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        endtask

        task check_verdict(input t_route_result r);
            t_route_result e;
            int            k;
            if (pending_verdicts.size() == 0) begin
                report("result with no packet pending, verdict", r.verdict, '0);
                return;
            end
            e = pending_verdicts.pop_front();
            if (r.verdict != e.verdict) report("verdict", r.verdict, e.verdict);
            if (r.ttl != e.ttl) report("ttl_out", r.ttl, e.ttl);
            for (k = 0; k < fmpr_pkg::FMPR_NUM_CNT; k++) begin
                if (r.cnt[k] != e.cnt[k])
                    report($sformatf("counter %0d", k), r.cnt[k], e.cnt[k]);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [3:0]  i_entry_slot;
    logic [31:0] i_entry_network;
    logic [5:0]  i_entry_prefix_len;
    logic [1:0]  i_entry_hop;
    logic [31:0] i_dest_addr;
    logic [15:0] i_ttl_in;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_verdict;
    logic [15:0] o_ttl_out;
    logic [31:0] o_direct_count;
    logic [31:0] o_hop_b_count;
    logic [31:0] o_hop_c_count;
    logic [31:0] o_unrouted_count;
    logic [31:0] o_expired_count;

    route_scoreboard sb;
    int              gap_pct   = 0;
    int              stall_pct = 0;
    int              quiet_cycles = 0;

    first_match_prefix_router DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_entry_slot       (i_entry_slot),
        .i_entry_network    (i_entry_network),
        .i_entry_prefix_len (i_entry_prefix_len),
        .i_entry_hop        (i_entry_hop),
        .i_dest_addr        (i_dest_addr),
        .i_ttl_in           (i_ttl_in),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_verdict          (o_verdict),
        .o_ttl_out          (o_ttl_out),
        .o_direct_count     (o_direct_count),
        .o_hop_b_count      (o_hop_b_count),
        .o_hop_c_count      (o_hop_c_count),
        .o_unrouted_count   (o_unrouted_count),
        .o_expired_count    (o_expired_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : input_monitor
        t_route_item it;
        if (i_rst_n && i_valid && o_ready) begin
            it.mode    = i_mode;
            it.slot    = i_entry_slot;
            it.network = i_entry_network;
            it.plen    = i_entry_prefix_len;
            it.hop     = i_entry_hop;
            it.dest    = i_dest_addr;
            it.ttl     = i_ttl_in;
            sb.route_accepted(it);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_route_result r;
        if (i_rst_n && o_valid && i_ready) begin
            r.verdict                     = fmpr_pkg::t_verdict'(o_verdict);
            r.ttl                         = o_ttl_out;
            r.cnt[fmpr_pkg::CNT_DIRECT]   = o_direct_count;
            r.cnt[fmpr_pkg::CNT_HOP_B]    = o_hop_b_count;
            r.cnt[fmpr_pkg::CNT_HOP_C]    = o_hop_c_count;
            r.cnt[fmpr_pkg::CNT_UNROUTED] = o_unrouted_count;
            r.cnt[fmpr_pkg::CNT_EXPIRED]  = o_expired_count;
            sb.check_verdict(r);
        end
    end

    // end the run if neither channel moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("[first_match_prefix_router] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_route_item load_item(input logic [3:0] slot, input logic [31:0] net,
                                              input logic [5:0] plen, input logic [1:0] hop);
        t_route_item it;
        it.mode    = MODE_LOAD;
        it.slot    = slot;
        it.network = net;
        it.plen    = plen;
        it.hop     = hop;
        it.dest    = $urandom;
        it.ttl     = $urandom;
        return it;
    endfunction

    function automatic t_route_item packet_item(input logic [31:0] dest, input logic [15:0] ttl);
        t_route_item it;
        it.mode    = MODE_PACKET;
        it.slot    = $urandom;
        it.network = $urandom;
        it.plen    = $urandom;
        it.hop     = $urandom;
        it.dest    = dest;
        it.ttl     = ttl;
        return it;
    endfunction

    function automatic t_route_item random_item();
        int          roll;
        int          span;
        int          j;
        logic [5:0]  plen;
        logic [31:0] net;
        logic [31:0] m;
        logic [31:0] dest;
        logic [15:0] ttl;
        if ($urandom_range(99) < 25) begin
            roll = $urandom_range(99);
            if (roll < 5) plen = 6'd0;
            else if (roll < 15) plen = $urandom_range(63, 33);
            else plen = $urandom_range(32, 1);
            net = $urandom;
            // mostly aligned networks; a few keep host bits and can never match
            if (plen == 6'd0) begin
                if ($urandom_range(1) == 1) net = '0;
            end else if ($urandom_range(9) != 0) begin
                net = net & sb.mask_of(plen);
            end
            return load_item($urandom_range(15), net, plen, $urandom_range(3));
        end
        roll = $urandom_range(99);
        if (roll < 8) ttl = 16'd1;
        else if (roll < 13) ttl = 16'd0;
        else if (roll < 16) ttl = 16'hFFFF;
        else ttl = $urandom_range(65535);
        span = (sb.entries > fmpr_pkg::FMPR_TABLE_DEPTH) ?
               fmpr_pkg::FMPR_TABLE_DEPTH : int'(sb.entries);
        roll = $urandom_range(99);
        if (roll < 10) begin
            dest = sb.blocked;
        end else if (roll < 70 && span > 0) begin
            j    = $urandom_range(span - 1);
            m    = sb.mask_of(sb.plen_tbl[j]);
            dest = (sb.net_tbl[j] & m) | ($urandom & ~m);
        end else begin
            dest = $urandom;
        end
        return packet_item(dest, ttl);
    endfunction

    task automatic send(input t_route_item it);
        @(negedge i_clk);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid            = 1'b1;
        i_mode             = it.mode;
        i_entry_slot       = it.slot;
        i_entry_network    = it.network;
        i_entry_prefix_len = it.plen;
        i_entry_hop        = it.hop;
        i_dest_addr        = it.dest;
        i_ttl_in           = it.ttl;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // a load leaves no result behind, so give the chain time to empty as well
    task automatic settle();
        drain_results();
        repeat (fmpr_pkg::FMPR_TABLE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_register(idx, data);
    endtask

    initial begin
        int          p;
        int          k;
        logic [4:0]  entries_plan [PHASES];
        logic [31:0] blocked_plan [PHASES];
        int          gap_plan     [4];
        int          stall_plan   [4];

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        i_valid            = 1'b0;
        i_mode             = MODE_LOAD;
        i_entry_slot       = '0;
        i_entry_network    = '0;
        i_entry_prefix_len = '0;
        i_entry_hop        = '0;
        i_dest_addr        = '0;
        i_ttl_in           = '0;
        i_ready            = 1'b0;
        sb                 = new();

        entries_plan = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd9};
        gap_plan     = '{0, 49, 0, 37};
        stall_plan   = '{0, 0, 49, 37};

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty search: blocked (ttl ignored), expired, wrapped ttl with no match
        send(packet_item(fmpr_pkg::FMPR_BLOCKED_RESET, 16'd1));
        send(packet_item(32'h0000_0000, 16'd1));
        send(packet_item(32'hFFFF_FFFF, 16'd0));

        // fill every slot before any search reaches the table
        send(load_item(4'd0, 32'hC0A8_0100, 6'd24, fmpr_pkg::HOP_B));
        send(load_item(4'd1, 32'h0A00_0000, 6'd8, fmpr_pkg::HOP_C));
        send(load_item(4'd2, 32'hAC10_0000, 6'd12, HOP_SPARE));
        send(load_item(4'd3, 32'hDEAD_BEEF, 6'd63, fmpr_pkg::HOP_B));
        send(load_item(4'd4, 32'h0B00_0001, 6'd8, fmpr_pkg::HOP_C));
        send(load_item(4'd5, 32'hFFFF_FFFF, 6'd32, HOP_DIRECT));
        send(load_item(4'd6, 32'hC0A8_0000, 6'd16, fmpr_pkg::HOP_C));
        send(load_item(4'd7, 32'h0B00_0000, 6'd8, fmpr_pkg::HOP_B));
        send(load_item(4'd8, 32'h0100_0000, 6'd0, fmpr_pkg::HOP_B));
        for (k = 9; k < 15; k++)
            send(load_item(k, 32'h6400_0000 | (k << 16), 6'd16, k));
        send(load_item(4'd15, 32'h0000_0000, 6'd0, fmpr_pkg::HOP_C));
        settle();
        write_reg(fmpr_pkg::CFG_ENTRIES, 32'd16);

        send(packet_item(32'hC0A8_0105, 16'd64));
        send(packet_item(32'hC0A8_0205, 16'd64));
        send(packet_item(32'h0A01_0203, 16'd2));
        send(packet_item(32'hAC1F_0001, 16'd255));
        send(packet_item(32'hDEAD_BEEF, 16'd9));
        send(packet_item(32'hDEAD_BEEE, 16'd9));
        send(packet_item(32'h0B00_0001, 16'd30));
        send(packet_item(32'hFFFF_FFFF, 16'd0));
        send(packet_item(fmpr_pkg::FMPR_BLOCKED_RESET, 16'd0));

        blocked_plan = '{$urandom, 32'h0000_0000, 32'hFFFF_FFFF,
                         fmpr_pkg::FMPR_BLOCKED_RESET, sb.net_tbl[0]};

        for (p = 0; p < PHASES; p++) begin
            settle();
            write_reg(fmpr_pkg::CFG_ENTRIES, ($urandom & 32'hFFFF_FFE0) | entries_plan[p]);
            write_reg(fmpr_pkg::CFG_BLOCKED, blocked_plan[p]);
            write_reg(CFG_SPARE_2, $urandom);
            write_reg(CFG_SPARE_3, $urandom);
            gap_pct   = gap_plan[p % 4];
            stall_pct = stall_plan[p % 4];
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold the sender now and then until every result is back
                if (k == PHASE_ITEMS / 3 || $urandom_range(59) == 0) drain_results();
                send(random_item());
            end
        end

        stall_pct = 0;
        settle();
        $display("covered %0d route loads and %0d packets over %0d table settings",
                 sb.loads_seen,
                 sb.verdict_tally[fmpr_pkg::V_DIRECT] + sb.verdict_tally[fmpr_pkg::V_HOP_B] +
                 sb.verdict_tally[fmpr_pkg::V_HOP_C] + sb.verdict_tally[fmpr_pkg::V_NOMATCH] +
                 sb.verdict_tally[fmpr_pkg::V_EXPIRED] + sb.verdict_tally[fmpr_pkg::V_BLOCKED],
                 PHASES + 1);
        $display("verdicts: direct %0d, B %0d, C %0d, no match %0d, expired %0d, blocked %0d",
                 sb.verdict_tally[fmpr_pkg::V_DIRECT], sb.verdict_tally[fmpr_pkg::V_HOP_B],
                 sb.verdict_tally[fmpr_pkg::V_HOP_C], sb.verdict_tally[fmpr_pkg::V_NOMATCH],
                 sb.verdict_tally[fmpr_pkg::V_EXPIRED], sb.verdict_tally[fmpr_pkg::V_BLOCKED]);
        if (sb.mismatches == 0) begin
            $display("[first_match_prefix_router] OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[first_match_prefix_router] ERROR");
        end
        $finish;
    end

endmodule
